FILE: rtl/core/bpfa_pkg.sv
// Shared codes, widths and types of the bitmap page frame allocator.
package bpfa_pkg;

  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 16;
  localparam int PAGE_W    = 20;
  localparam int ADDR_W    = 32;
  localparam int OFFSET_W  = 12;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int LIMIT_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISALIGN = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE   = 2'd1;

  localparam logic [CNT_W-1:0]  FRAME_COUNT_RST = 16'd32768;
  localparam logic [PAGE_W-1:0] BASE_PAGE_RST   = 20'd0;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_res_t;

endpackage

FILE: rtl/core/bitmap_page_frame_allocator.sv
// Top level of the bitmap first-fit page frame allocator.
//
//  channel | ports                                  | transfer when
//  --------+----------------------------------------+--------------------------
//  input   | in_valid in_ready in_command in_address | in_valid && in_ready
//  result  | out_valid out_ready out_status          |
//          |   out_frame_address                    | out_valid && out_ready
//  config  | cfg_we cfg_index cfg_wdata             | cfg_we (no wait)
//
// One command at a time. Alloc reads one bitmap word per cycle from the map
// RAM and scans at most the words that hold live frames; init sweeps every
// map word; free checks the address, then reads and rewrites one map word
// unless rejected. The single read port of the map RAM sets the alloc scan
// rate. After reset a clearing pass zeroes the map with in_ready low. A
// result waits in the output register until taken; the next command is
// accepted meanwhile and holds in its final state only if the output
// register is still full.
module bitmap_page_frame_allocator #(
  parameter int MAX_FRAMES = 32768
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bpfa_pkg::CMD_W-1:0]          in_command,
  input  logic [bpfa_pkg::ADDR_W-1:0]         in_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bpfa_pkg::STATUS_W-1:0]       out_status,
  output logic [bpfa_pkg::ADDR_W-1:0]         out_frame_address,
  input  logic                                cfg_we,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import bpfa_pkg::*;

  localparam int MAP_WORDS = (MAX_FRAMES + 31) / 32;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = WADDR_W + BIT_W;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CLEAR    = 6'b000010,
    ST_SCAN     = 6'b000100,
    ST_FREE_CHK = 6'b001000,
    ST_FREE_WR  = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  init_sweep_r, init_sweep_nxt;
  logic [WADDR_W-1:0]    sweep_w_r, sweep_w_nxt;
  logic [WADDR_W:0]      issue_w_r, issue_w_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [WADDR_W-1:0]    chk_w_r, chk_w_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [CNT_W-1:0]      frame_count_r;
  logic [PAGE_W-1:0]     base_page_r;

  logic                  ram_we, ram_re;
  logic [WADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  logic [CNT_W-1:0]      live_n;
  logic [CNT_W:0]        words_sum;
  logic [CNT_W-5:0]      words_n;
  logic                  issue_ok;
  logic [31:0]           rem_bits;
  logic [LIMIT_W-1:0]    find_limit;
  find_res_t             find_res;
  logic [IDX_W-1:0]      alloc_idx;
  logic [PAGE_W-1:0]     alloc_page;
  logic [PAGE_W-1:0]     free_page;
  logic [PAGE_W-1:0]     free_diff;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_misalign;
  logic                  free_out_range;

  // Config registers: write only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
      base_page_r   <= BASE_PAGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_BASE_PAGE:   base_page_r   <= cfg_wdata[PAGE_W-1:0];
        default:         ;
      endcase
    end
  end

  // Live frame count saturates at the map size.
  always_comb begin
    if (32'(frame_count_r) > 32'(MAX_FRAMES)) begin
      live_n = CNT_W'(MAX_FRAMES);
    end else begin
      live_n = frame_count_r;
    end
  end

  // Number of map words that hold at least one managed frame.
  assign words_sum = {1'b0, live_n} + (CNT_W + 1)'(WORD_W - 1);
  assign words_n   = words_sum[CNT_W:BIT_W];
  assign issue_ok  = 32'(issue_w_r) < 32'(words_n);

  // Frames of the word under test that lie below the live count.
  assign rem_bits   = 32'(live_n) - (32'(chk_w_r) << BIT_W);
  assign find_limit = (rem_bits >= 32'(WORD_W)) ? LIMIT_W'(WORD_W) : rem_bits[LIMIT_W-1:0];

  bpfa_word_find u_find (
    .map_word (ram_rdata),
    .limit    (find_limit),
    .res      (find_res)
  );

  assign alloc_idx  = {chk_w_r, find_res.bit_idx};
  assign alloc_page = base_page_r + PAGE_W'(alloc_idx);

  // Free address checks; alignment goes first.
  assign free_page      = addr_r[ADDR_W-1:OFFSET_W];
  assign free_diff      = free_page - base_page_r;
  assign free_misalign  = addr_r[OFFSET_W-1:0] != '0;
  assign free_out_range = (free_page < base_page_r) || (free_diff >= PAGE_W'(live_n));
  assign free_idx       = IDX_W'(free_diff);

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    init_sweep_nxt = init_sweep_r;
    sweep_w_nxt    = sweep_w_r;
    issue_w_nxt    = issue_w_r;
    chk_vld_nxt    = 1'b0;
    chk_w_nxt      = chk_w_r;
    addr_nxt       = addr_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    ram_we         = 1'b0;
    ram_waddr      = sweep_w_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = issue_w_r[WADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          addr_nxt       = in_address;
          res_status_nxt = STATUS_OK;
          res_addr_nxt   = '0;
          case (in_command)
            CMD_INIT: begin
              state_nxt      = ST_CLEAR;
              init_sweep_nxt = 1'b1;
              sweep_w_nxt    = '0;
            end
            CMD_ALLOC: begin
              state_nxt   = ST_SCAN;
              issue_w_nxt = '0;
            end
            CMD_FREE: begin
              state_nxt = ST_FREE_CHK;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        // Zero one word per cycle; init reserves frame 0 for the map if
        // the count is nonzero, as count / 32768 is at most one for 16 bits.
        ram_we    = 1'b1;
        ram_waddr = sweep_w_r;
        ram_wdata = (init_sweep_r && sweep_w_r == '0 && live_n != '0) ? WORD_W'(1) : '0;
        if (32'(sweep_w_r) == 32'(MAP_WORDS - 1)) begin
          state_nxt = init_sweep_r ? ST_DONE : ST_IDLE;
        end else begin
          sweep_w_nxt = sweep_w_r + WADDR_W'(1);
        end
      end

      ST_SCAN: begin
        if (chk_vld_r && find_res.found) begin
          // Mark the frame used and stop.
          ram_we         = 1'b1;
          ram_waddr      = chk_w_r;
          ram_wdata      = ram_rdata | (WORD_W'(1) << find_res.bit_idx);
          res_status_nxt = STATUS_OK;
          res_addr_nxt   = {alloc_page, OFFSET_W'(0)};
          state_nxt      = ST_DONE;
        end else if (!chk_vld_r && !issue_ok) begin
          res_status_nxt = STATUS_NO_FRAME;
          res_addr_nxt   = '0;
          state_nxt      = ST_DONE;
        end else if (issue_ok) begin
          // Stream the next word while the current one is tested.
          ram_re      = 1'b1;
          ram_raddr   = issue_w_r[WADDR_W-1:0];
          issue_w_nxt = issue_w_r + (WADDR_W + 1)'(1);
          chk_vld_nxt = 1'b1;
          chk_w_nxt   = issue_w_r[WADDR_W-1:0];
        end
      end

      ST_FREE_CHK: begin
        if (free_misalign) begin
          res_status_nxt = STATUS_MISALIGN;
          state_nxt      = ST_DONE;
        end else if (free_out_range) begin
          res_status_nxt = STATUS_RANGE;
          state_nxt      = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = free_idx[IDX_W-1:BIT_W];
          state_nxt = ST_FREE_WR;
        end
      end

      ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = free_idx[IDX_W-1:BIT_W];
        ram_wdata = ram_rdata & ~(WORD_W'(1) << free_idx[BIT_W-1:0]);
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Hold the result until the output register has room.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      init_sweep_r <= 1'b0;
      sweep_w_r    <= '0;
      issue_w_r    <= '0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_sweep_r <= init_sweep_nxt;
      sweep_w_r    <= sweep_w_nxt;
      issue_w_r    <= issue_w_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_w_r      <= chk_w_nxt;
    addr_r       <= addr_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  bpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_address = out_addr_r;

  // A failed command never reports a frame address.
  a_addr_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STATUS_OK |-> out_addr_r == '0)
    else $error("frame address nonzero on error status");

  // An accepted command always leaves idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted command did not start");

  // The map is written only by the sweep, an alloc hit or a free.
  a_map_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_SCAN || state_r == ST_FREE_WR))
    else $error("map write outside a writing state");

  // An alloc hit returns the page of the word just tested.
  a_alloc_hit_checked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && ram_we |-> chk_vld_r && find_res.found)
    else $error("alloc wrote a word that was not tested");

endmodule

FILE: rtl/core/bpfa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bpfa_word_find.sv
// Lowest free frame search inside one bitmap word, limited to the managed frames.
module bpfa_word_find (
  input  logic [bpfa_pkg::WORD_W-1:0]  map_word,
  input  logic [bpfa_pkg::LIMIT_W-1:0] limit,
  output bpfa_pkg::find_res_t          res
);

  import bpfa_pkg::*;

  logic [WORD_W-1:0] free_vec;

  // a bit counts as free only below the limit of managed frames
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      free_vec[b] = !map_word[b] && (LIMIT_W'(b) < limit);
    end
  end

  // priority encode, lowest bit wins
  always_comb begin
    res.found   = |free_vec;
    res.bit_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        res.bit_idx = BIT_W'(b);
      end
    end
  end

endmodule

FILE: verif/bpfa_tb_pkg.sv
// Frame map predictor and reply checker for the bitmap page frame allocator bench.
package bpfa_tb_pkg;
  import bpfa_pkg::*;

  localparam int MAX_FRAMES   = 32768;
  localparam int MAP_WORDS    = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int RESERVE_SPAN = 32768;  // frames whose bits fit in one map frame
  localparam int REPORT_LIMIT = 10;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    int unsigned         seq;
    logic [CMD_W-1:0]    command;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   frame_address;
  } frame_reply_t;

  class frame_map_board;
    logic [WORD_W-1:0] used_words [MAP_WORDS];
    logic [CNT_W-1:0]  frame_count;
    logic [PAGE_W-1:0] base_page;
    frame_reply_t      reply_q [$];
    int unsigned       accepted;
    int unsigned       fault_count;

    function new();
      foreach (used_words[w]) used_words[w] = '0;
      frame_count = FRAME_COUNT_RST;
      base_page   = BASE_PAGE_RST;
      accepted    = 0;
      fault_count = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_FRAME_COUNT: frame_count = data[CNT_W-1:0];
        CFG_BASE_PAGE:   base_page   = data[PAGE_W-1:0];
        default: ;
      endcase
    endfunction

    // Counts above the map size saturate.
    function int unsigned managed_frames();
      return (frame_count > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count);
    endfunction

    function int first_open_frame(int unsigned n);
      for (int w = 0; w < MAP_WORDS && w * WORD_W < n; w++) begin
        if (&used_words[w]) continue;
        for (int b = 0; b < WORD_W; b++) begin
          if (w * WORD_W + b >= n) return -1;
          if (!used_words[w][b]) return w * WORD_W + b;
        end
      end
      return -1;
    endfunction

    function void note_command(logic [CMD_W-1:0] command, logic [ADDR_W-1:0] address);
      frame_reply_t      reply;
      int unsigned       n;
      int unsigned       reserve;
      int unsigned       slot;
      int                hit;
      logic [PAGE_W-1:0] page;
      n = managed_frames();
      reply.seq           = accepted;
      reply.command       = command;
      reply.status        = STATUS_OK;
      reply.frame_address = '0;
      accepted++;
      case (command)
        CMD_INIT: begin
          foreach (used_words[w]) used_words[w] = '0;
          reserve = n / RESERVE_SPAN;
          if (reserve == 0) reserve = 1;
          if (reserve > n) reserve = n;
          for (int unsigned i = 0; i < reserve; i++) used_words[i / WORD_W][i % WORD_W] = 1'b1;
        end
        CMD_ALLOC: begin
          hit = first_open_frame(n);
          if (hit < 0) begin
            reply.status = STATUS_NO_FRAME;
          end else begin
            used_words[hit / WORD_W][hit % WORD_W] = 1'b1;
            reply.frame_address = (ADDR_W'(base_page) + ADDR_W'(hit)) << OFFSET_W;
          end
        end
        CMD_FREE: begin
          page = address[ADDR_W-1:OFFSET_W];
          if (address[OFFSET_W-1:0] != '0) begin
            reply.status = STATUS_MISALIGN;
          end else if (page < base_page || 32'(page) - 32'(base_page) >= n) begin
            reply.status = STATUS_RANGE;
          end else begin
            slot = 32'(page) - 32'(base_page);
            used_words[slot / WORD_W][slot % WORD_W] = 1'b0;
          end
        end
        default: ;
      endcase
      reply_q.push_back(reply);
    endfunction

    function void flag(string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("mismatch: %s", what);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] frame_address);
      frame_reply_t want;
      if (reply_q.size() == 0) begin
        flag($sformatf("result with nothing outstanding: status %0d frame_address %h",
                       status, frame_address));
        return;
      end
      want = reply_q.pop_front();
      if (status !== want.status)
        flag($sformatf("item %0d cmd %0d status: expected %0d, got %0d",
                       want.seq, want.command, want.status, status));
      if (frame_address !== want.frame_address)
        flag($sformatf("item %0d cmd %0d frame_address: expected %h, got %h",
                       want.seq, want.command, want.frame_address, frame_address));
    endfunction

    function int unsigned pending();
      return reply_q.size();
    endfunction
  endclass

endpackage

FILE: verif/bitmap_page_frame_allocator_tb.sv
// Testbench top for the bitmap page frame allocator: stimulus, flow control and checks.
module bitmap_page_frame_allocator_tb;
  import bpfa_pkg::*;
  import bpfa_tb_pkg::*;

  localparam int IDLE_PCT       = 38;     // chance per cycle that a side idles
  localparam int ITEM_TARGET    = 580;
  localparam int SQUEEZE_CYCLES = 400;    // receiver hold-off that backs up the block
  localparam int SETTLE_CYCLES  = 8;      // quiet cycles after the last reply
  localparam int STALL_LIMIT    = 20000;  // init sweep + hold-off, many times over

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command        = CMD_INIT;
  logic [ADDR_W-1:0]     in_address        = '0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ADDR_W-1:0]     out_frame_address;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = CFG_FRAME_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata         = '0;

  // Stimulus-owned knobs, written with nonblocking assignments only.
  logic                  calm_stretch      = 1'b0;
  int unsigned           squeeze_req       = 0;
  int unsigned           items_sent        = 0;

  frame_map_board board = new();

  bitmap_page_frame_allocator #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_frame_address(out_frame_address),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one command and hold it until the transfer. Entered and left at a
  // rising edge; valid is left high, so the next command drops it only to idle.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
    if (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm_stretch && $urandom_range(99) < IDLE_PCT);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    board.note_command(cmd, addr);
    items_sent <= items_sent + 1;
  endtask

  // Drop valid, wait out every outstanding reply, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram the frame window; only ever done with the block idle.
  task automatic set_frames(input logic write_count, input int unsigned count,
                            input logic write_base, input int unsigned base);
    drain();
    if (write_count) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_FRAME_COUNT;
      cfg_wdata <= CFG_DATA_W'(count);
      @(posedge clk);
      board.write_register(CFG_FRAME_COUNT, CFG_DATA_W'(count));
    end
    if (write_base) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_BASE_PAGE;
      cfg_wdata <= CFG_DATA_W'(base);
      @(posedge clk);
      board.write_register(CFG_BASE_PAGE, CFG_DATA_W'(base));
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly allocs and frees aimed at managed frames, so the map fills and
  // drains; the rest is init, misaligned, stray and unused-code traffic.
  task automatic run_phase(input int unsigned len);
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    int unsigned       n;
    int unsigned       pick;
    int unsigned       idx;
    for (int unsigned k = 0; k < len; k++) begin
      n    = board.managed_frames();
      pick = $urandom_range(99);
      addr = $urandom;
      if (pick < 4) begin
        cmd = CMD_INIT;
      end else if (pick < 50) begin
        cmd = CMD_ALLOC;
      end else if (pick < 96) begin
        cmd = CMD_FREE;
        if (pick < 88) begin
          // hit a managed frame, now and then one just past the top
          idx  = (n == 0 || $urandom_range(9) == 0) ? n + $urandom_range(3)
                                                     : $urandom_range(n - 1);
          addr = (ADDR_W'(board.base_page) + ADDR_W'(idx)) << OFFSET_W;
        end else if (pick < 92) begin
          if (addr[OFFSET_W-1:0] == '0) addr[0] = 1'b1;
        end else begin
          addr[OFFSET_W-1:0] = '0;
        end
      end else begin
        cmd = CMD_UNUSED;
      end
      send_command(cmd, addr);
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned count;
    int unsigned base;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window: full map, base 0. Alloc before any init sees an empty map.
    send_command(CMD_ALLOC, 32'hFFFF_FFFF);
    send_command(CMD_INIT,  32'h0000_0000);
    send_command(CMD_ALLOC, 32'h0000_0000);
    send_command(CMD_ALLOC, 32'h1234_5678);
    send_command(CMD_FREE,  32'h0000_2000);
    send_command(CMD_FREE,  32'h0000_2000);  // already free: still ok
    send_command(CMD_FREE,  32'h0000_2001);  // misaligned
    send_command(CMD_FREE,  32'hFFFF_FFFF);  // misaligned wins over range
    send_command(CMD_FREE,  32'hFFFF_F000);  // far past the top
    send_command(CMD_FREE,  32'h0800_0000);  // exactly at the count
    send_command(CMD_FREE,  32'h07FF_F000);  // last managed frame
    send_command(CMD_UNUSED, 32'hFFFF_FFFF);
    send_command(CMD_FREE,  32'h0000_0000);  // release the reserved frame
    send_command(CMD_ALLOC, 32'h0000_0000);

    // Empty window: nothing reserved, nothing to hand out, every free rejected.
    set_frames(1'b1, 0, 1'b0, 0);
    send_command(CMD_INIT,  32'h0000_0000);
    send_command(CMD_ALLOC, 32'h0000_0000);
    send_command(CMD_FREE,  32'h0000_0000);

    // Saturated count at the top base page: alloc address wraps to zero.
    set_frames(1'b1, 16'hFFFF, 1'b1, 20'hFFFFF);
    send_command(CMD_INIT,  32'h0000_0000);
    send_command(CMD_ALLOC, 32'h0000_0000);
    send_command(CMD_FREE,  32'hFFFF_F000);
    send_command(CMD_FREE,  32'h0000_1000);  // below base

    // Single frame, taken by the map itself.
    set_frames(1'b1, 1, 1'b1, 5);
    send_command(CMD_INIT,  32'h0000_0000);
    send_command(CMD_ALLOC, 32'h0000_0000);
    send_command(CMD_FREE,  32'h0000_5000);
    send_command(CMD_ALLOC, 32'h0000_0000);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(15))
        0:       count = 0;
        1:       count = 1;
        2:       count = 32;
        3:       count = 33;
        4:       count = 31;
        5:       count = MAX_FRAMES;
        6:       count = 16'hFFFF;
        7:       count = $urandom_range(16'hFFFF, MAX_FRAMES + 1);
        8:       count = $urandom_range(16'hFFFF, 1);
        default: count = $urandom_range(96, 2);
      endcase
      case ($urandom_range(5))
        0, 1:    base = 0;
        2:       base = 20'hFFFFF;
        3:       base = 20'hFFFFF - $urandom_range(64);
        default: base = $urandom_range(20'hFFFFF);
      endcase
      // Skipping the init now and then keeps stale bits past a new count.
      set_frames(phase == 0 || $urandom_range(3) != 0, count,
                 phase == 0 || $urandom_range(1) == 1, base);
      calm_stretch <= (phase == 3);
      if (phase == 2 || phase == 6) squeeze_req <= squeeze_req + 1;
      if ($urandom_range(9) < 7) send_command(CMD_INIT, $urandom);
      run_phase(phase == 3 ? 90 : $urandom_range(70, 30));
      phase++;
    end

    drain();
    if (board.fault_count == 0)
      $display("bitmap_page_frame_allocator_tb: clean");
    else
      $display("bitmap_page_frame_allocator_tb: errors");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold-off on request so the
  // block backs up into its input while the sender keeps offering.
  initial begin : result_sink
    int unsigned seen_req;
    int unsigned hold;
    seen_req = 0;
    hold     = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req != seen_req) begin
        seen_req = squeeze_req;
        hold     = SQUEEZE_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_status, out_frame_address);
  end

  // Give up when no transfer happens on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("bitmap_page_frame_allocator_tb: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_ram.sv
rtl/core/bpfa_word_find.sv
rtl/core/bitmap_page_frame_allocator.sv
verif/bpfa_tb_pkg.sv
verif/bitmap_page_frame_allocator_tb.sv
